// File: rtl/core/rrq_pkg.sv
`timescale 1ns / 1ps
package rrq_pkg;

  // Default sizes
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int ID_WIDTH_DEF       = 8;
  localparam int PRIORITY_WIDTH_DEF = 8;

  // Fixed field widths
  localparam int OP_WIDTH     = 3;
  localparam int STATUS_WIDTH = 2;

  // Operation codes
  typedef enum logic [OP_WIDTH-1:0] {
    OP_INSERT    = 3'd0,
    OP_POP       = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_SUCCESSOR = 3'd3,
    OP_PEEK      = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic load;    // write the new entry into the slot at the tail
    logic rotate;  // every slot takes its neighbor, the tail slot takes the head
  } cell_cmd_t;

endpackage

// File: rtl/core/rrq_req_if.sv
`timescale 1ns / 1ps
interface rrq_req_if
  import rrq_pkg::*;
#(
  parameter int ID_WIDTH       = ID_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic [OP_WIDTH-1:0]       operation;
  logic [ID_WIDTH-1:0]       task_id;
  logic [PRIORITY_WIDTH-1:0] task_priority;

  modport source (output valid, operation, task_id, task_priority, input ready);
  modport sink   (input valid, operation, task_id, task_priority, output ready);
endinterface

// File: rtl/core/rrq_rsp_if.sv
`timescale 1ns / 1ps
interface rrq_rsp_if
  import rrq_pkg::*;
#(
  parameter int ID_WIDTH       = ID_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
  parameter int COUNT_WIDTH    = $clog2(QUEUE_DEPTH_DEF + 1)
);
  logic                      valid;
  logic                      ready;
  logic [STATUS_WIDTH-1:0]   status;
  logic                      result_valid;
  logic [ID_WIDTH-1:0]       result_id;
  logic [PRIORITY_WIDTH-1:0] result_priority;
  logic [COUNT_WIDTH-1:0]    entry_count;
  logic                      is_empty;

  modport source (output valid, status, result_valid, result_id, result_priority,
                  entry_count, is_empty, input ready);
  modport sink   (input valid, status, result_valid, result_id, result_priority,
                  entry_count, is_empty, output ready);
endinterface

// File: rtl/core/rrq_cell.sv
`timescale 1ns / 1ps
module rrq_cell
  import rrq_pkg::*;
#(
  parameter int SLOT           = 0,
  parameter int ID_WIDTH       = ID_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
  parameter int COUNT_WIDTH    = $clog2(QUEUE_DEPTH_DEF + 1)
) (
  input  logic                      clk,
  input  cell_cmd_t                 cmd,
  input  logic [COUNT_WIDTH-1:0]    count,
  input  logic [ID_WIDTH-1:0]       new_id,
  input  logic [PRIORITY_WIDTH-1:0] new_priority,
  input  logic [ID_WIDTH-1:0]       nbr_id,
  input  logic [PRIORITY_WIDTH-1:0] nbr_priority,
  input  logic [ID_WIDTH-1:0]       head_id,
  input  logic [PRIORITY_WIDTH-1:0] head_priority,
  output logic [ID_WIDTH-1:0]       slot_id,
  output logic [PRIORITY_WIDTH-1:0] slot_priority
);

  logic is_tail_free;
  logic is_last;

  // Position of this slot relative to the current fill level
  assign is_tail_free = (count == COUNT_WIDTH'(SLOT));
  assign is_last      = (count == COUNT_WIDTH'(SLOT + 1));

  // Slot storage: load at the tail, or shift toward the head with wrap
  always_ff @(posedge clk) begin
    if (cmd.load && is_tail_free) begin
      slot_id       <= new_id;
      slot_priority <= new_priority;
    end else if (cmd.rotate) begin
      if (is_last) begin
        slot_id       <= head_id;
        slot_priority <= head_priority;
      end else begin
        slot_id       <= nbr_id;
        slot_priority <= nbr_priority;
      end
    end
  end

endmodule

// File: rtl/core/round_robin_run_queue.sv
`timescale 1ns / 1ps
// Round-robin run queue of (task_id, task_priority) entries in arrival order.
// req channel: one operation per transfer (insert, pop, remove by id,
// successor of id, peek, clear). rsp channel: one result per operation with
// status, returned entry, entry count and empty flag after the operation.
// Entries sit in a chain of slot cells; slot 0 is the head. Insert, pop,
// peek and clear finish in the accept cycle: the result is registered and
// shows on rsp the next cycle. Remove and successor rotate the whole chain
// through the head comparator once, one slot per cycle; the result is
// registered after the pass over all entries (in the accept cycle when the
// queue is empty); a remove drops the matching entry during that pass.
// One operation is in flight at a time; req is ready again once the result
// register is free or being taken.
// A stalled rsp holds its result and keeps req from being accepted.
// Reset (synchronous, rst high) empties the queue and drops any pending
// result; slot contents are not cleared.
module round_robin_run_queue
  import rrq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH       = ID_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  rrq_req_if.sink   req,
  rrq_rsp_if.source rsp
);

  localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                    state;
  logic [CountWidth-1:0]     count;
  logic [CountWidth-1:0]     count_next;
  logic [CountWidth-1:0]     remaining;
  logic [ID_WIDTH-1:0]       key_id;
  logic                      scan_remove;
  logic                      found;
  logic                      res_valid;
  logic [ID_WIDTH-1:0]       res_id;
  logic [PRIORITY_WIDTH-1:0] res_priority;

  logic                      req_fire;
  logic                      head_hit;
  cell_cmd_t                 cmd;

  logic [ID_WIDTH-1:0]       ids  [QUEUE_DEPTH];
  logic [PRIORITY_WIDTH-1:0] pris [QUEUE_DEPTH];

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign head_hit  = (ids[0] == key_id);

  // Chain of slot cells; the last cell's neighbor wraps to the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0]       nbr_id;
    logic [PRIORITY_WIDTH-1:0] nbr_priority;

    if (i == QUEUE_DEPTH - 1) begin : g_wrap
      assign nbr_id       = ids[0];
      assign nbr_priority = pris[0];
    end else begin : g_link
      assign nbr_id       = ids[i+1];
      assign nbr_priority = pris[i+1];
    end

    rrq_cell #(
      .SLOT          (i),
      .ID_WIDTH      (ID_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH),
      .COUNT_WIDTH   (CountWidth)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .count        (count),
      .new_id       (req.task_id),
      .new_priority (req.task_priority),
      .nbr_id       (nbr_id),
      .nbr_priority (nbr_priority),
      .head_id      (ids[0]),
      .head_priority(pris[0]),
      .slot_id      (ids[i]),
      .slot_priority(pris[i])
    );
  end

  // Cell command and next fill level
  always_comb begin
    cmd        = '0;
    count_next = count;
    if (state == S_IDLE) begin
      if (req_fire) begin
        case (req.operation)
          OP_INSERT: begin
            if (count != CountWidth'(QUEUE_DEPTH)) begin
              cmd.load   = 1'b1;
              count_next = count + CountWidth'(1);
            end
          end
          OP_POP: begin
            if (count != '0) begin
              cmd.rotate = 1'b1;
              count_next = count - CountWidth'(1);
            end
          end
          OP_CLEAR: count_next = '0;
          default: ;
        endcase
      end
    end else begin
      // Scan pass: rotate every cycle; a remove hit drops the head instead
      if (remaining != '0) begin
        cmd.rotate = 1'b1;
        if (!found && head_hit && scan_remove) begin
          count_next = count - CountWidth'(1);
        end
      end
    end
  end

  // Control state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            rsp.status          <= STATUS_OK;
            rsp.result_valid    <= 1'b0;
            rsp.result_id       <= '0;
            rsp.result_priority <= '0;
            rsp.entry_count     <= count_next;
            rsp.is_empty        <= (count_next == '0);
            rsp.valid           <= 1'b1;
            case (req.operation)
              OP_INSERT: begin
                if (count == CountWidth'(QUEUE_DEPTH)) begin
                  rsp.status <= STATUS_FULL;
                end
              end
              OP_POP, OP_PEEK: begin
                if (count == '0) begin
                  rsp.status <= STATUS_EMPTY;
                end else begin
                  rsp.result_valid    <= 1'b1;
                  rsp.result_id       <= ids[0];
                  rsp.result_priority <= pris[0];
                end
              end
              OP_REMOVE, OP_SUCCESSOR: begin
                if (count == '0) begin
                  rsp.status <= STATUS_EMPTY;
                end else begin
                  rsp.valid    <= 1'b0;
                  state        <= S_SCAN;
                  remaining    <= count;
                  key_id       <= req.task_id;
                  scan_remove  <= (req.operation == OP_REMOVE);
                  found        <= 1'b0;
                  res_valid    <= 1'b0;
                  res_id       <= '0;
                  res_priority <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (remaining == '0) begin
            // Chain is back in original order; report
            state               <= S_IDLE;
            rsp.valid           <= 1'b1;
            rsp.status          <= found ? STATUS_OK : STATUS_NOT_FOUND;
            rsp.result_valid    <= res_valid;
            rsp.result_id       <= res_id;
            rsp.result_priority <= res_priority;
            rsp.entry_count     <= count;
            rsp.is_empty        <= (count == '0);
          end else begin
            remaining <= remaining - CountWidth'(1);
            if (!found && head_hit) begin
              found <= 1'b1;
              // Successor sits next to the head in the ring
              if (!scan_remove && count != CountWidth'(1)) begin
                res_valid    <= 1'b1;
                res_id       <= ids[1];
                res_priority <= pris[1];
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
